>>> design/pdt_pkg.sv
`default_nettype none
package pdt_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TICK_BITS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TAG_W     = 8;
    localparam int OVR_W     = 8;
    localparam int DIV_CNT_W = $clog2(TICK_BITS);

    localparam logic [OVR_W-1:0] OVR_MAX = {OVR_W{1'b1}};

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        OP_SCHEDULE = 3'd0,
        OP_COMPLETE = 3'd1,
        OP_SET_EN   = 3'd2,
        OP_LOAD     = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [31:0]          period;
        logic [31:0]          deadline;
        logic [TICK_BITS-1:0] ready_time;
    } entry_t;

endpackage
`default_nettype wire

>>> design/periodic_task_dispatcher.sv
// Periodic task dispatcher: a table of eight tasks held in one synchronous
// memory (tag, period, deadline, ready time) plus flip-flop enable bits.
// Input channel s_*: one item per command (schedule pass, completion,
// set enable by tag, load entry, clear overrun count). Output channel m_*:
// exactly one result item per input item, in order.
// Load, clear and unused codes go straight to the result. A completion
// reads the running entry, if any, and a set-enable walk reads each entry
// in use. A schedule pass reads the entries in use in turn and stops at
// the first due, enabled one; for each due entry the realignment remainder
// comes from a restoring divider that yields one bit per cycle (32 steps).
// One item is worked at a time; the next item is taken as soon as the
// sequencer is idle, while the previous result may still sit in the
// output register.
// Reset (aresetn low, synchronous) clears all enable bits, the running
// entry, the overrun counter and task_count; table contents stay undefined
// until loaded. When the receiver stalls, the finished result holds in the
// output register and the sequencer waits before posting the next one.
`default_nettype none
module periodic_task_dispatcher
    import pdt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [3:0]           cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // operation[2:0], tick[34:3], task_tag[42:35], set_active[43],
    // update_last_run[44], entry_index[47:45], task_period[79:48],
    // task_deadline[111:80]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // dispatched[0], dispatch_index[3:1], dispatch_tag[11:4],
    // overrun_seen[12], overrun_count[20:13], zero[23:21]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_WB,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [3:0]           task_count_reg;
    logic [2:0]           op_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic                 act_reg;
    logic                 restamp_reg;
    logic [CNT_W-1:0]     walk_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [MAX_TASKS-1:0] enable_reg;
    logic [IDX_W-1:0]     running_entry_reg;
    logic                 running_valid_reg;
    logic [OVR_W-1:0]     overrun_reg;
    logic [TICK_BITS-1:0] div_rem_reg;
    logic [TICK_BITS-1:0] div_dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                 disp_reg;
    logic [IDX_W-1:0]     disp_idx_reg;
    logic [TAG_W-1:0]     disp_tag_reg;
    logic                 seen_reg;
    logic                 m_tvalid_reg;

    entry_t               mem [MAX_TASKS];
    entry_t               rd_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    // input field views
    logic [2:0]           in_op;
    logic [TICK_BITS-1:0] in_tick;
    logic [TAG_W-1:0]     in_tag;
    logic                 in_act;
    logic                 in_restamp;
    logic [IDX_W-1:0]     in_idx;
    logic [31:0]          in_period;
    logic [31:0]          in_deadline;

    assign in_op       = s_tdata[2:0];
    assign in_tick     = s_tdata[34:3];
    assign in_tag      = s_tdata[42:35];
    assign in_act      = s_tdata[43];
    assign in_restamp  = s_tdata[44];
    assign in_idx      = s_tdata[47:45];
    assign in_period   = s_tdata[79:48];
    assign in_deadline = s_tdata[111:80];

    logic                 accept;
    logic [IDX_W-1:0]     walk_idx;
    logic [CNT_W-1:0]     walk_inc;
    logic [TICK_BITS-1:0] elapsed;
    logic [TICK_BITS-1:0] period_eff;
    logic [TICK_BITS:0]   div_trial;
    logic [TICK_BITS-1:0] div_step;
    logic                 out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign walk_idx = walk_reg[IDX_W-1:0];
    assign walk_inc = walk_reg + CNT_W'(1);
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_addr    = (op_reg == OP_COMPLETE) ? running_entry_reg : walk_idx;
    assign elapsed    = tick_reg - rd_data.ready_time;
    assign period_eff = (rd_data.period == 32'd0) ? TICK_BITS'(1) : rd_data.period;
    assign div_trial  = {div_rem_reg, div_dvd_reg[TICK_BITS-1]};
    assign div_step   = (div_trial >= {1'b0, period_eff})
                      ? TICK_BITS'(div_trial - {1'b0, period_eff})
                      : div_trial[TICK_BITS-1:0];

    // memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = walk_idx;
        wr_data = rd_data;
        if (accept && in_op == OP_LOAD) begin
            wr_en   = 1'b1;
            wr_addr = in_idx;
            wr_data.tag        = in_tag;
            wr_data.period     = in_period;
            wr_data.deadline   = in_deadline;
            wr_data.ready_time = in_tick;
        end else if (state_reg == ST_EVAL && op_reg == OP_SET_EN
                     && rd_data.tag == tag_reg && restamp_reg) begin
            wr_en              = 1'b1;
            wr_data.ready_time = tick_reg;
        end else if (state_reg == ST_WB) begin
            wr_en              = 1'b1;
            wr_data.ready_time = tick_reg - div_rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            task_count_reg    <= '0;
            enable_reg        <= '0;
            running_entry_reg <= '0;
            running_valid_reg <= 1'b0;
            overrun_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                task_count_reg <= cfg_wdata;
            end
            // post a finished result, or drop the one just taken
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg       <= in_op;
                        tick_reg     <= in_tick;
                        tag_reg      <= in_tag;
                        act_reg      <= in_act;
                        restamp_reg  <= in_restamp;
                        walk_reg     <= '0;
                        n_reg        <= (task_count_reg > 4'(MAX_TASKS))
                                      ? CNT_W'(MAX_TASKS) : CNT_W'(task_count_reg);
                        disp_reg     <= 1'b0;
                        disp_idx_reg <= '0;
                        disp_tag_reg <= '0;
                        seen_reg     <= 1'b0;
                        unique case (in_op)
                            OP_SCHEDULE, OP_SET_EN: begin
                                state_reg <= (task_count_reg != 4'd0) ? ST_READ : ST_DONE;
                            end
                            OP_COMPLETE: begin
                                running_valid_reg <= 1'b0;
                                state_reg         <= running_valid_reg ? ST_READ : ST_DONE;
                            end
                            OP_LOAD: begin
                                enable_reg[in_idx] <= in_act;
                                state_reg          <= ST_DONE;
                            end
                            OP_CLEAR: begin
                                overrun_reg <= '0;
                                state_reg   <= ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    unique case (op_reg)
                        OP_SCHEDULE: begin
                            if (elapsed >= period_eff) begin
                                div_rem_reg <= '0;
                                div_dvd_reg <= elapsed;
                                div_cnt_reg <= '0;
                                state_reg   <= ST_DIV;
                            end else begin
                                walk_reg  <= walk_inc;
                                state_reg <= (walk_inc == n_reg) ? ST_DONE : ST_READ;
                            end
                        end
                        OP_COMPLETE: begin
                            if (elapsed > rd_data.deadline) begin
                                seen_reg <= 1'b1;
                                if (overrun_reg != OVR_MAX) begin
                                    overrun_reg <= overrun_reg + OVR_W'(1);
                                end
                            end
                            state_reg <= ST_DONE;
                        end
                        default: begin
                            if (rd_data.tag == tag_reg) begin
                                enable_reg[walk_idx] <= act_reg;
                            end
                            walk_reg  <= walk_inc;
                            state_reg <= (walk_inc == n_reg) ? ST_DONE : ST_READ;
                        end
                    endcase
                end
                ST_DIV: begin
                    // one remainder bit per cycle
                    div_rem_reg <= div_step;
                    div_dvd_reg <= {div_dvd_reg[TICK_BITS-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(TICK_BITS - 1)) begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    if (enable_reg[walk_idx]) begin
                        disp_reg          <= 1'b1;
                        disp_idx_reg      <= walk_idx;
                        disp_tag_reg      <= rd_data.tag;
                        running_entry_reg <= walk_idx;
                        running_valid_reg <= 1'b1;
                        state_reg         <= ST_DONE;
                    end else begin
                        walk_reg  <= walk_inc;
                        state_reg <= (walk_inc == n_reg) ? ST_DONE : ST_READ;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    logic                 m_disp_reg;
    logic [IDX_W-1:0]     m_idx_reg;
    logic [TAG_W-1:0]     m_tag_reg;
    logic                 m_seen_reg;
    logic [OVR_W-1:0]     m_cnt_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_disp_reg <= disp_reg;
            m_idx_reg  <= disp_idx_reg;
            m_tag_reg  <= disp_tag_reg;
            m_seen_reg <= seen_reg;
            m_cnt_reg  <= overrun_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_seen_reg, m_tag_reg, m_idx_reg, m_disp_reg};

endmodule
`default_nettype wire
